/* rtl/core/fsqf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fsqf_pkg;

    // Fixed field widths
    localparam int MODE_W   = 2;
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 2;
    localparam int FLEN_W   = 13;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FLUSHED = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic step;     // execute the accepted word this cycle
    } t_dp_cmd;

endpackage

`default_nettype wire

/* rtl/core/fsqf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module fsqf_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output fsqf_pkg::t_dp_cmd     o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_OUT  = 1'b1;

    logic r_state;
    logic n_state;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_cmd.step  = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/fsqf_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module fsqf_datapath #(
    parameter int SLOT_COUNT = 2,
    parameter int SLOT_BYTES = 4096
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  fsqf_pkg::t_dp_cmd                   i_cmd,
    input  wire  [fsqf_pkg::MODE_W-1:0]         i_mode,
    input  wire  [fsqf_pkg::DATA_W-1:0]         i_write_data,
    input  wire                                 i_last_byte,
    output logic [fsqf_pkg::STATUS_W-1:0]       o_status,
    output logic [fsqf_pkg::DATA_W-1:0]         o_read_data,
    output logic                                o_frame_end,
    output logic [fsqf_pkg::FLEN_W-1:0]         o_frame_length
);

    localparam int DEPTH  = SLOT_COUNT * SLOT_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int HELD_W = $clog2(SLOT_COUNT + 1);
    localparam int OFF_W  = $clog2(SLOT_BYTES);
    localparam int LEN_W  = $clog2(SLOT_BYTES + 1);

    // Queue pointers
    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic [HELD_W-1:0] r_held, n_held;
    logic [LEN_W-1:0]  r_woff, n_woff;
    logic [OFF_W-1:0]  r_roff, n_roff;
    logic              r_open, n_open;

    // Storage
    logic [fsqf_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [fsqf_pkg::DATA_W-1:0] r_mem_q;
    logic [LEN_W-1:0]            r_len [SLOT_COUNT];

    // Result registers
    logic [fsqf_pkg::STATUS_W-1:0] r_status, n_status;
    logic                          r_byte_rd, n_byte_rd;
    logic                          r_fend, n_fend;
    logic [fsqf_pkg::FLEN_W-1:0]   r_flen, n_flen;

    // Memory / length-table controls
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic              len_we;
    logic [SLOT_W-1:0] len_slot;
    logic [LEN_W-1:0]  len_val;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    always_comb begin
        logic              flush;
        logic [SLOT_W-1:0] tail_e;
        logic [HELD_W-1:0] held_e;
        logic [LEN_W-1:0]  woff_e;
        logic [LEN_W-1:0]  woff_inc;
        logic              fits;
        logic [LEN_W-1:0]  cur_len;
        logic [LEN_W-1:0]  roff_inc;

        n_head    = r_head;
        n_tail    = r_tail;
        n_held    = r_held;
        n_woff    = r_woff;
        n_roff    = r_roff;
        n_open    = r_open;
        n_status  = r_status;
        n_byte_rd = r_byte_rd;
        n_fend    = r_fend;
        n_flen    = r_flen;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = '0;
        len_we    = 1'b0;
        len_slot  = r_tail;
        len_val   = '0;

        // Write-side working values (flush on a new frame into a full queue)
        flush    = !r_open && (r_held == HELD_W'(SLOT_COUNT));
        tail_e   = flush ? '0 : r_tail;
        held_e   = flush ? '0 : r_held;
        woff_e   = r_open ? r_woff : '0;
        fits     = (woff_e < LEN_W'(SLOT_BYTES));
        woff_inc = fits ? woff_e + LEN_W'(1) : woff_e;

        cur_len  = r_len[r_head];
        roff_inc = LEN_W'(r_roff) + LEN_W'(1);

        if (i_cmd.step) begin
            n_status  = fsqf_pkg::ST_OK;
            n_byte_rd = 1'b0;
            n_fend    = 1'b0;
            n_flen    = '0;
            case (i_mode)
                fsqf_pkg::MODE_WRITE: begin
                    if (flush) begin
                        n_head   = '0;
                        n_roff   = '0;
                        n_status = fsqf_pkg::ST_FLUSHED;
                    end else if (!fits) begin
                        n_status = fsqf_pkg::ST_DROPPED;
                    end
                    mem_we   = fits;
                    mem_addr = ADDR_W'(tail_e) * ADDR_W'(SLOT_BYTES)
                             + ADDR_W'(woff_e[OFF_W-1:0]);
                    if (i_last_byte) begin
                        len_we   = 1'b1;
                        len_slot = tail_e;
                        len_val  = woff_inc;
                        n_tail   = next_slot(tail_e);
                        n_held   = held_e + HELD_W'(1);
                        n_open   = 1'b0;
                        n_woff   = '0;
                    end else begin
                        n_tail = tail_e;
                        n_held = held_e;
                        n_open = 1'b1;
                        n_woff = woff_inc;
                    end
                end
                fsqf_pkg::MODE_READ: begin
                    if (r_held == '0) begin
                        n_status = fsqf_pkg::ST_EMPTY;
                    end else begin
                        mem_re    = 1'b1;
                        mem_addr  = ADDR_W'(r_head) * ADDR_W'(SLOT_BYTES)
                                  + ADDR_W'(r_roff);
                        n_byte_rd = 1'b1;
                        n_flen    = fsqf_pkg::FLEN_W'(cur_len);
                        if (roff_inc >= cur_len) begin
                            n_fend = 1'b1;
                            n_roff = '0;
                            n_head = next_slot(r_head);
                            n_held = r_held - HELD_W'(1);
                        end else begin
                            n_roff = roff_inc[OFF_W-1:0];
                        end
                    end
                end
                fsqf_pkg::MODE_CLEAR: begin
                    n_head = '0;
                    n_tail = '0;
                    n_held = '0;
                    n_roff = '0;
                    n_open = 1'b0;
                    n_woff = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_held <= '0;
            r_woff <= '0;
            r_roff <= '0;
            r_open <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_held <= n_held;
            r_woff <= n_woff;
            r_roff <= n_roff;
            r_open <= n_open;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_byte_rd <= n_byte_rd;
        r_fend    <= n_fend;
        r_flen    <= n_flen;
    end

    // Slot memory: one port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= i_write_data;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_len[len_slot] <= len_val;
        end
    end

    assign o_status       = r_status;
    assign o_read_data    = r_byte_rd ? r_mem_q : '0;
    assign o_frame_end    = r_fend;
    assign o_frame_length = r_flen;

endmodule

`default_nettype wire

/* rtl/core/frame_slot_queue_flush_on_overflow_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Valid          Ready          Word
// -------  -------------  -------------  ---------------------------------------------
// in       i_in_valid     o_in_ready     i_mode, i_write_data, i_last_byte
// out      o_out_valid    i_out_ready    o_status, o_read_data, o_frame_end,
//                                        o_frame_length
//
// Each input word gives exactly one output word. A word is executed on the
// cycle it is accepted; its result is valid on the next cycle, once the slot
// memory's registered read has landed. The next input word is taken the cycle
// after the result is taken, so the block holds only one word at a time.
// Reset (synchronous, active low) empties the queue; slot memory and stored
// lengths are not cleared and need no clearing pass.
module frame_slot_queue_flush_on_overflow_top #(
    parameter int SLOT_COUNT = 2,
    parameter int SLOT_BYTES = 4096
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // input word
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  [fsqf_pkg::MODE_W-1:0]         i_mode,
    input  wire  [fsqf_pkg::DATA_W-1:0]         i_write_data,
    input  wire                                 i_last_byte,
    // result word
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [fsqf_pkg::STATUS_W-1:0]       o_status,
    output logic [fsqf_pkg::DATA_W-1:0]         o_read_data,
    output logic                                o_frame_end,
    output logic [fsqf_pkg::FLEN_W-1:0]         o_frame_length
);

    fsqf_pkg::t_dp_cmd cmd;

    // Handshake sequencing: idle -> result pending -> idle
    fsqf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // Queue pointers, slot memory, length table and result registers
    fsqf_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_mode         (i_mode),
        .i_write_data   (i_write_data),
        .i_last_byte    (i_last_byte),
        .o_status       (o_status),
        .o_read_data    (o_read_data),
        .o_frame_end    (o_frame_end),
        .o_frame_length (o_frame_length)
    );

endmodule

`default_nettype wire

/* test/tb_frame_slot_queue_flush_on_overflow_top.sv */
`timescale 1ns / 1ps

module tb_frame_slot_queue_flush_on_overflow_top;

    localparam int SLOT_COUNT = 2;
    localparam int SLOT_BYTES = 4096;
    localparam int RANDOM_WORDS = 700;
    localparam int MODE_W   = fsqf_pkg::MODE_W;
    localparam int DATA_W   = fsqf_pkg::DATA_W;
    localparam int STATUS_W = fsqf_pkg::STATUS_W;
    localparam int FLEN_W   = fsqf_pkg::FLEN_W;
    // mode code the block must ignore
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // one result word as the block should produce it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   read_data;
        logic                frame_end;
        logic [FLEN_W-1:0]   frame_length;
    } t_queue_result;

    // Tracks the slot queue contents and checks result words in order.
    class t_frame_queue_tracker;
        logic [DATA_W-1:0] slot_mem [SLOT_COUNT*SLOT_BYTES];
        int slot_len [SLOT_COUNT];
        int head_slot = 0;
        int tail_slot = 0;
        int frames_held = 0;
        int write_offset = 0;
        int read_offset = 0;
        bit frame_open = 0;

        t_queue_result awaited[$];
        int errors = 0;
        int n_words = 0;
        int n_bytes_read = 0;
        int n_empty = 0;
        int n_dropped = 0;
        int n_flushed = 0;
        int n_frames = 0;

        function int next_slot(int s);
            return (s + 1 >= SLOT_COUNT) ? 0 : s + 1;
        endfunction

        function void empty_queue();
            head_slot = 0;
            tail_slot = 0;
            frames_held = 0;
            read_offset = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Apply one accepted word to the queue and note the result it must give.
        function void take_word(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] data,
                                logic last);
            t_queue_result r;
            int off;
            r = '0;
            case (mode)
                fsqf_pkg::MODE_WRITE: begin
                    if (!frame_open) begin
                        if (frames_held >= SLOT_COUNT) begin
                            empty_queue();
                            r.status = fsqf_pkg::ST_FLUSHED;
                        end
                        frame_open = 1;
                        write_offset = 0;
                    end
                    if (write_offset < SLOT_BYTES) begin
                        slot_mem[tail_slot*SLOT_BYTES + write_offset] = data;
                        write_offset++;
                    end else if (r.status == fsqf_pkg::ST_OK) begin
                        r.status = fsqf_pkg::ST_DROPPED;
                    end
                    if (last) begin
                        slot_len[tail_slot] = write_offset;
                        tail_slot = next_slot(tail_slot);
                        frames_held++;
                        frame_open = 0;
                        write_offset = 0;
                        n_frames++;
                    end
                end
                fsqf_pkg::MODE_READ: begin
                    if (frames_held == 0) begin
                        r.status = fsqf_pkg::ST_EMPTY;
                    end else begin
                        off = read_offset;
                        if (off >= SLOT_BYTES) off = SLOT_BYTES - 1;
                        r.read_data = slot_mem[head_slot*SLOT_BYTES + off];
                        r.frame_length = FLEN_W'(slot_len[head_slot]);
                        read_offset = off + 1;
                        if (read_offset >= slot_len[head_slot]) begin
                            r.frame_end = 1'b1;
                            read_offset = 0;
                            head_slot = next_slot(head_slot);
                            frames_held--;
                        end
                        n_bytes_read++;
                    end
                end
                fsqf_pkg::MODE_CLEAR: begin
                    empty_queue();
                    frame_open = 0;
                    write_offset = 0;
                end
                default: ;
            endcase
            case (r.status)
                fsqf_pkg::ST_EMPTY:   n_empty++;
                fsqf_pkg::ST_DROPPED: n_dropped++;
                fsqf_pkg::ST_FLUSHED: n_flushed++;
                default: ;
            endcase
            n_words++;
            awaited.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            $display("%0t: %s got %0d, expected %0d", $realtime, what, got, want);
        endtask

        task check_word(t_queue_result got);
            t_queue_result want;
            if (awaited.size() == 0) begin
                report_mismatch("result word with nothing outstanding, status", got.status, 0);
            end else begin
                want = awaited.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
                if (got.frame_end !== want.frame_end)
                    report_mismatch("frame_end", got.frame_end, want.frame_end);
                if (got.frame_length !== want.frame_length)
                    report_mismatch("frame_length", got.frame_length, want.frame_length);
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [MODE_W-1:0]   i_mode;
    logic [DATA_W-1:0]   i_write_data;
    logic                i_last_byte;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [STATUS_W-1:0] o_status;
    logic [DATA_W-1:0]   o_read_data;
    logic                o_frame_end;
    logic [FLEN_W-1:0]   o_frame_length;

    t_frame_queue_tracker tracker;
    bit calm;           // when set, neither side idles
    int words_sent;     // accepted words, spare mode excluded

    frame_slot_queue_flush_on_overflow_top #(
        .SLOT_COUNT(SLOT_COUNT),
        .SLOT_BYTES(SLOT_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_write_data  (i_write_data),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_read_data   (o_read_data),
        .o_frame_end   (o_frame_end),
        .o_frame_length(o_frame_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop. Slowest legal run is roughly 800 words, each bounded by the capped
    // input gap, the capped output stall and the handshake itself, ~160 us.
    initial begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: ready drops about a third of the time, with runs of low ready
    // capped by low_run; held high throughout calm stretches.
    initial begin
        int low_run;
        low_run = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm || low_run >= 6 || $urandom_range(0, 2) != 0) begin
                i_out_ready <= 1'b1;
                low_run = 0;
            end else begin
                i_out_ready <= 1'b0;
                low_run++;
            end
        end
    end

    // Sample accepted results at the rising edge, in order.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_word({o_status, o_read_data, o_frame_end, o_frame_length});
    end

    function automatic int pick_gap();
        int g;
        g = 0;
        if (!calm)
            while (g < 8 && $urandom_range(0, 2) == 0) g++;
        return g;
    endfunction

    // Present one word after a random gap and hold it until taken.
    task automatic send_word(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] data,
                             logic last);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_write_data <= data;
        i_last_byte  <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.take_word(mode, data, last);
        if (mode != MODE_SPARE) words_sent++;
    endtask

    // Write len random bytes; flag the final one as last only when closing.
    task automatic push_frame(int len, bit close);
        for (int k = 0; k < len; k++)
            send_word(fsqf_pkg::MODE_WRITE, DATA_W'($urandom_range(0, 255)),
                      close && (k == len - 1));
    endtask

    // Reads carry random don't-care payload so every input bit toggles.
    task automatic read_burst(int n);
        repeat (n)
            send_word(fsqf_pkg::MODE_READ, DATA_W'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
    endtask

    initial begin
        int pick;
        int base;
        int len;
        tracker = new;
        calm = 1'b0;
        words_sent = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_mode = fsqf_pkg::MODE_WRITE;
        i_write_data = '0;
        i_last_byte = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed ----
        read_burst(1);                                      // read from an empty queue
        send_word(MODE_SPARE, 8'hFF, 1'b1);                 // unused mode, ignored
        send_word(fsqf_pkg::MODE_WRITE, 8'h00, 1'b0);       // three-byte frame, data extremes
        send_word(fsqf_pkg::MODE_WRITE, 8'hFF, 1'b0);
        send_word(fsqf_pkg::MODE_WRITE, 8'h5A, 1'b1);
        send_word(fsqf_pkg::MODE_WRITE, 8'hA5, 1'b0);       // open a second frame...
        read_burst(3);                                      // ...first frame drains meanwhile
        read_burst(1);                                      // open frame stays invisible
        send_word(fsqf_pkg::MODE_WRITE, 8'hC3, 1'b1);
        send_word(fsqf_pkg::MODE_WRITE, 8'h11, 1'b1);       // both slots now hold frames
        push_frame(3, 1'b1);                                // first byte flushes the queue
        read_burst(4);                                      // drain it, then empty again
        push_frame(2, 1'b0);
        send_word(fsqf_pkg::MODE_CLEAR, 8'h00, 1'b0);       // clear abandons the open frame
        push_frame(2, 1'b1);
        send_word(fsqf_pkg::MODE_CLEAR, 8'hFF, 1'b1);       // clear drops a committed frame
        read_burst(1);

        // ---- random: mostly whole frames and read bursts ----
        base = words_sent;
        while (words_sent < base + RANDOM_WORDS) begin
            calm = (words_sent >= base + 300) && (words_sent < base + 420);
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                  : $urandom_range(1, 10);
                push_frame(len, 1'b1);
            end else if (pick < 80) begin
                read_burst($urandom_range(1, 16));
            end else if (pick < 88) begin
                push_frame($urandom_range(1, 5), 1'b0);
                send_word(fsqf_pkg::MODE_CLEAR, DATA_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end else if (pick < 94) begin
                push_frame($urandom_range(1, 3), 1'b0);   // later writes resume it
            end else if (pick < 97) begin
                send_word(fsqf_pkg::MODE_CLEAR, DATA_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end else begin
                send_word(MODE_SPARE, DATA_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end
        end
        calm = 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // drain, then a short settle for anything stray
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Ran %0d words: %0d frames committed, %0d bytes read back.",
                 tracker.n_words, tracker.n_frames, tracker.n_bytes_read);
        $display("Saw %0d empty reads, %0d dropped bytes, %0d overflow flushes.",
                 tracker.n_empty, tracker.n_dropped, tracker.n_flushed);
        if (tracker.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/fsqf_pkg.sv
rtl/core/fsqf_ctrl.sv
rtl/core/fsqf_datapath.sv
rtl/core/frame_slot_queue_flush_on_overflow_top.sv
test/tb_frame_slot_queue_flush_on_overflow_top.sv
